// File: src/i2c_rft_pkg.sv
// Shared types, constants and helpers of the I2C register file target.
package i2c_rft_pkg;

  localparam int REG_COUNT_DEF     = 16;
  localparam int CAPTURE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [7:0] REG0_RESET = 8'hA5;
  localparam logic [7:0] REG1_RESET = 8'h5A;

  localparam int TRACE_REG_W = 4;
  localparam int TRACE_LEN_W = 5;

  // Request codes as they arrive on req_type.
  typedef enum logic [2:0] {
    REQ_START_WR = 3'd0,
    REQ_START_RD = 3'd1,
    REQ_FINISH   = 3'd2,
    REQ_WRITE    = 3'd3,
    REQ_READ     = 3'd4,
    REQ_SET_REG  = 3'd5,
    REQ_FAULT    = 3'd6,
    REQ_RESET    = 3'd7
  } req_t;

  // Classified operations handed from front to back.
  typedef enum logic [3:0] {
    OP_START_WR,
    OP_START_RD,
    OP_FINISH,
    OP_WRITE,
    OP_READ,
    OP_SET_REG,
    OP_SET_BAD,
    OP_FAULT_ONCE,
    OP_FAULT_LATCH,
    OP_RESET,
    OP_RESET_BAD
  } op_t;

  typedef enum logic [1:0] {
    KIND_BUS_REPLY = 2'd0,
    KIND_TRACE_HDR = 2'd1,
    KIND_TRACE_DAT = 2'd2,
    KIND_CTRL_ACK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DATA,
    S_REPLY
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  byte_val;
    logic [7:0]  quot;
    logic [7:0]  reg_index;
    logic [63:0] time_ns;
  } cmd_t;

  typedef struct packed {
    kind_t                    result_kind;
    logic                     nack;
    logic [7:0]               data_byte;
    logic                     trace_result;
    logic [31:0]              trace_number;
    logic [63:0]              trace_time;
    logic                     trace_is_read;
    logic [TRACE_REG_W-1:0]   trace_pointer;
    logic [TRACE_LEN_W-1:0]   trace_length;
    logic                     accepted;
    logic                     error_code;
    logic                     last;
  } rsp_t;

  // Value of a register that has not been written since reset.
  function automatic logic [7:0] reg_reset_val(input logic [7:0] idx);
    logic [7:0] val;
    val = 8'h00;
    if (idx == 8'd0) begin
      val = REG0_RESET;
    end else if (idx == 8'd1) begin
      val = REG1_RESET;
    end
    return val;
  endfunction

endpackage

// File: src/i2c_rft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module i2c_rft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/i2c_rft_front.sv
// Front end: accepts request beats and classifies them into commands.
module i2c_rft_front
  import i2c_rft_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        req_valid,
  input  logic [2:0]  req_type,
  input  logic [7:0]  bus_byte,
  input  logic [7:0]  reg_index,
  input  logic [7:0]  reg_value,
  input  logic        one_shot,
  input  logic [63:0] time_ns,
  input  logic        q_full,
  output logic        req_stall,
  output logic        push,
  output cmd_t        push_cmd
);

  // Reciprocal for the pointer modulo; exact for every 8-bit byte.
  localparam int RECIP = (65536 + REG_COUNT - 1) / REG_COUNT;

  logic [23:0] quot_prod;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;
  assign quot_prod = 24'(bus_byte) * 24'(RECIP);

  always_comb begin
    push_cmd.byte_val  = bus_byte;
    push_cmd.quot      = quot_prod[23:16];
    push_cmd.reg_index = reg_index;
    push_cmd.time_ns   = time_ns;
    push_cmd.op        = OP_FINISH;
    unique case (req_t'(req_type))
      REQ_START_WR: push_cmd.op = OP_START_WR;
      REQ_START_RD: push_cmd.op = OP_START_RD;
      REQ_FINISH:   push_cmd.op = OP_FINISH;
      REQ_WRITE:    push_cmd.op = OP_WRITE;
      REQ_READ:     push_cmd.op = OP_READ;
      REQ_SET_REG: begin
        push_cmd.byte_val = reg_value;
        push_cmd.op = (9'(reg_index) >= 9'(REG_COUNT)) ? OP_SET_BAD : OP_SET_REG;
      end
      REQ_FAULT:    push_cmd.op = one_shot ? OP_FAULT_ONCE : OP_FAULT_LATCH;
      REQ_RESET:    push_cmd.op = one_shot ? OP_RESET_BAD : OP_RESET;
      default:      push_cmd.op = OP_FINISH;
    endcase
  end

endmodule

// File: src/i2c_rft_queue.sv
// Short command queue between the front and back ends.
module i2c_rft_queue
  import i2c_rft_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;

  assign full      = (count == QCW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/i2c_rft_back.sv
// Back end: executes commands, owns the register file and trace capture.
module i2c_rft_back
  import i2c_rft_pkg::*;
#(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  cmd_t q_head,
  output logic pop,
  input  logic rsp_stall,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int PW = $clog2(REG_COUNT);
  localparam int CW = $clog2(CAPTURE_DEPTH + 1);
  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  state_t         state, state_next;
  cmd_t           cmd, cmd_next;
  logic [PW-1:0]  reg_ptr, reg_ptr_next;
  logic [CW-1:0]  cap_count, cap_count_next;
  logic           cap_dir, cap_dir_next;
  logic [PW-1:0]  cap_reg, cap_reg_next;
  logic           expect_ptr, expect_ptr_next;
  logic           in_tx, in_tx_next;
  logic           fault_latched, fault_latched_next;
  logic           fault_once, fault_once_next;
  logic [31:0]    seq, seq_next;
  logic [CW-1:0]  data_idx, data_idx_next;
  logic           reply_nack, reply_nack_next;
  logic [REG_COUNT-1:0] reg_valid, reg_valid_next;

  logic           out_free;
  logic           out_load;
  rsp_t           out_d;

  logic           reg_we;
  logic [PW-1:0]  reg_waddr;
  logic [7:0]     reg_wdata;
  logic [7:0]     reg_rdata;
  logic [7:0]     reg_val;
  logic           cap_we;
  logic [7:0]     cap_wdata;
  logic [AW-1:0]  cap_raddr;
  logic [7:0]     cap_rdata;

  logic [15:0]    rem_prod;
  logic [7:0]     rem;
  logic [PW-1:0]  ptr_inc;
  logic [CW-1:0]  idx_inc;
  logic           fault_armed;

  assign out_free    = !rsp_valid || !rsp_stall;
  assign rem_prod    = 16'(cmd.quot) * 16'(REG_COUNT);
  assign rem         = cmd.byte_val - rem_prod[7:0];
  assign ptr_inc     = (reg_ptr == PW'(REG_COUNT - 1)) ? '0 : reg_ptr + 1'b1;
  assign idx_inc     = data_idx + CW'(1);
  assign fault_armed = fault_latched || fault_once;
  assign reg_val     = reg_valid[reg_ptr] ? reg_rdata : reg_reset_val(8'(reg_ptr));
  assign cap_raddr   = (state != S_DATA) ? '0 :
                       (out_free ? idx_inc[AW-1:0] : data_idx[AW-1:0]);

  i2c_rft_ram #(.WIDTH(8), .DEPTH(REG_COUNT), .AW(PW)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (reg_waddr),
    .wdata (reg_wdata),
    .raddr (reg_ptr),
    .rdata (reg_rdata)
  );

  i2c_rft_ram #(.WIDTH(8), .DEPTH(CAPTURE_DEPTH), .AW(AW)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (cap_count[AW-1:0]),
    .wdata (cap_wdata),
    .raddr (cap_raddr),
    .rdata (cap_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_not_empty) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
          if ((cmd.op == OP_START_WR || cmd.op == OP_START_RD) && fault_armed) begin
            state_next = S_REPLY;
          end else if (cmd.op == OP_FINISH && in_tx) begin
            state_next = (cap_count != '0) ? S_DATA : S_REPLY;
          end
        end
      end
      S_DATA: begin
        if (out_free && idx_inc == cap_count) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Actions and emitted beats.
  always_comb begin
    cmd_next           = cmd;
    reg_ptr_next       = reg_ptr;
    cap_count_next     = cap_count;
    cap_dir_next       = cap_dir;
    cap_reg_next       = cap_reg;
    expect_ptr_next    = expect_ptr;
    in_tx_next         = in_tx;
    fault_latched_next = fault_latched;
    fault_once_next    = fault_once;
    seq_next           = seq;
    data_idx_next      = data_idx;
    reply_nack_next    = reply_nack;
    reg_valid_next     = reg_valid;
    pop                = 1'b0;
    out_load           = 1'b0;
    out_d              = '0;
    reg_we             = 1'b0;
    reg_waddr          = reg_ptr;
    reg_wdata          = cmd.byte_val;
    cap_we             = 1'b0;
    cap_wdata          = cmd.byte_val;

    unique case (state)
      S_IDLE: begin
        if (q_not_empty) begin
          pop      = 1'b1;
          cmd_next = q_head;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = KIND_BUS_REPLY;
          out_d.last        = 1'b1;
          unique case (cmd.op)
            OP_START_WR, OP_START_RD: begin
              cap_count_next  = '0;
              cap_dir_next    = (cmd.op == OP_START_RD);
              cap_reg_next    = reg_ptr;
              expect_ptr_next = (cmd.op == OP_START_WR);
              if (fault_armed) begin
                // Refused: header first, the nack reply follows.
                fault_once_next       = 1'b0;
                in_tx_next            = 1'b0;
                seq_next              = seq + 32'd1;
                reply_nack_next       = 1'b1;
                out_d.result_kind     = KIND_TRACE_HDR;
                out_d.last            = 1'b0;
                out_d.trace_result    = 1'b1;
                out_d.trace_number    = seq + 32'd1;
                out_d.trace_time      = cmd.time_ns;
                out_d.trace_is_read   = (cmd.op == OP_START_RD);
                out_d.trace_pointer   = TRACE_REG_W'(reg_ptr);
              end else begin
                in_tx_next = 1'b1;
              end
            end
            OP_FINISH: begin
              in_tx_next = 1'b0;
              if (in_tx) begin
                seq_next              = seq + 32'd1;
                reply_nack_next       = 1'b0;
                data_idx_next         = '0;
                out_d.result_kind     = KIND_TRACE_HDR;
                out_d.last            = 1'b0;
                out_d.trace_number    = seq + 32'd1;
                out_d.trace_time      = cmd.time_ns;
                out_d.trace_is_read   = cap_dir;
                out_d.trace_pointer   = TRACE_REG_W'(cap_reg);
                out_d.trace_length    = TRACE_LEN_W'(cap_count);
              end
            end
            OP_WRITE: begin
              if (cap_count < CW'(CAPTURE_DEPTH)) begin
                cap_we         = 1'b1;
                cap_count_next = cap_count + CW'(1);
              end
              if (expect_ptr) begin
                reg_ptr_next    = rem[PW-1:0];
                cap_reg_next    = rem[PW-1:0];
                expect_ptr_next = 1'b0;
              end else begin
                reg_we                  = 1'b1;
                reg_valid_next[reg_ptr] = 1'b1;
                reg_ptr_next            = ptr_inc;
              end
            end
            OP_READ: begin
              cap_wdata = reg_val;
              if (cap_count < CW'(CAPTURE_DEPTH)) begin
                cap_we         = 1'b1;
                cap_count_next = cap_count + CW'(1);
              end
              reg_ptr_next    = ptr_inc;
              out_d.data_byte = reg_val;
            end
            OP_SET_REG: begin
              reg_we                               = 1'b1;
              reg_waddr                            = cmd.reg_index[PW-1:0];
              reg_valid_next[cmd.reg_index[PW-1:0]] = 1'b1;
              out_d.result_kind                    = KIND_CTRL_ACK;
              out_d.accepted                       = 1'b1;
            end
            OP_SET_BAD, OP_RESET_BAD: begin
              out_d.result_kind = KIND_CTRL_ACK;
              out_d.error_code  = 1'b1;
            end
            OP_FAULT_ONCE: begin
              fault_once_next   = 1'b1;
              out_d.result_kind = KIND_CTRL_ACK;
              out_d.accepted    = 1'b1;
            end
            OP_FAULT_LATCH: begin
              fault_latched_next = 1'b1;
              out_d.result_kind  = KIND_CTRL_ACK;
              out_d.accepted     = 1'b1;
            end
            OP_RESET: begin
              reg_valid_next     = '0;
              reg_ptr_next       = '0;
              cap_count_next     = '0;
              cap_dir_next       = 1'b0;
              cap_reg_next       = '0;
              expect_ptr_next    = 1'b1;
              in_tx_next         = 1'b0;
              fault_latched_next = 1'b0;
              fault_once_next    = 1'b0;
              seq_next           = '0;
              out_d.result_kind  = KIND_CTRL_ACK;
              out_d.accepted     = 1'b1;
            end
            default: begin
              out_d.result_kind = KIND_CTRL_ACK;
              out_d.error_code  = 1'b1;
            end
          endcase
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = KIND_TRACE_DAT;
          out_d.data_byte   = cap_rdata;
          data_idx_next     = idx_inc;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = KIND_BUS_REPLY;
          out_d.nack        = reply_nack;
          out_d.last        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    if (out_load) begin
      rsp <= out_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      reg_ptr       <= '0;
      cap_count     <= '0;
      cap_dir       <= 1'b0;
      cap_reg       <= '0;
      expect_ptr    <= 1'b1;
      in_tx         <= 1'b0;
      fault_latched <= 1'b0;
      fault_once    <= 1'b0;
      seq           <= '0;
      data_idx      <= '0;
      reply_nack    <= 1'b0;
      reg_valid     <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      reg_ptr       <= reg_ptr_next;
      cap_count     <= cap_count_next;
      cap_dir       <= cap_dir_next;
      cap_reg       <= cap_reg_next;
      expect_ptr    <= expect_ptr_next;
      in_tx         <= in_tx_next;
      fault_latched <= fault_latched_next;
      fault_once    <= fault_once_next;
      seq           <= seq_next;
      data_idx      <= data_idx_next;
      reply_nack    <= reply_nack_next;
      reg_valid     <= reg_valid_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/i2c_register_file_target.sv
// A request beat passes through the command queue and the command register to the
// response register; a busy back end or rsp_stall can hold it. The back-end sequencer
// runs one command at a time; a finish in a transaction emits a header, a data beat per
// captured byte and a reply. The two-entry command queue accepts requests while the back
// end is busy. Reset: rst is synchronous, active high; it empties the queue and
// restores control state; the soft reset command resets the register file and trace.
module i2c_register_file_target
  import i2c_rft_pkg::*;
#(
  parameter int REG_COUNT     = REG_COUNT_DEF,
  parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [7:0]  bus_byte,
  input  logic [7:0]  reg_index,
  input  logic [7:0]  reg_value,
  input  logic        one_shot,
  input  logic [63:0] time_ns,
  // Response channel.
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  result_kind,
  output logic        nack,
  output logic [7:0]  data_byte,
  output logic        trace_result,
  output logic [31:0] trace_number,
  output logic [63:0] trace_time,
  output logic        trace_is_read,
  output logic [3:0]  trace_pointer,
  output logic [4:0]  trace_length,
  output logic        accepted,
  output logic        error_code,
  output logic        last
);

  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_head;
  rsp_t rsp;

  // Front: classify each request beat and compute the pointer quotient.
  i2c_rft_front #(.REG_COUNT(REG_COUNT)) u_front (
    .req_valid (req_valid),
    .req_type  (req_type),
    .bus_byte  (bus_byte),
    .reg_index (reg_index),
    .reg_value (reg_value),
    .one_shot  (one_shot),
    .time_ns   (time_ns),
    .q_full    (q_full),
    .req_stall (req_stall),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Hold classified commands until the back end is free.
  i2c_rft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: execute commands and drive the registered response beat.
  i2c_rft_back #(
    .REG_COUNT     (REG_COUNT),
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp)
  );

  // Unpack the response register onto the ports.
  assign result_kind     = rsp.result_kind;
  assign nack            = rsp.nack;
  assign data_byte       = rsp.data_byte;
  assign trace_result    = rsp.trace_result;
  assign trace_number    = rsp.trace_number;
  assign trace_time      = rsp.trace_time;
  assign trace_is_read   = rsp.trace_is_read;
  assign trace_pointer   = rsp.trace_pointer;
  assign trace_length    = rsp.trace_length;
  assign accepted        = rsp.accepted;
  assign error_code      = rsp.error_code;
  assign last            = rsp.last;

endmodule
